// ===== rtl/core/clt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the command line tokenizer.
// Depends on nothing; compiled first.
package clt_pkg;

  localparam int MAX_RESULTS = 4;
  localparam int COUNT_W     = 3;
  localparam int INDEX_W     = 2;

  // lexer phase codes
  localparam logic [3:0] PH_TEXT    = 4'd0;
  localparam logic [3:0] PH_DASH    = 4'd1;
  localparam logic [3:0] PH_OPT     = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_PATH    = 4'd4;
  localparam logic [3:0] PH_NUM     = 4'd5;
  localparam logic [3:0] PH_FRAC    = 4'd6;
  localparam logic [3:0] PH_EMARK   = 4'd7;
  localparam logic [3:0] PH_ESIGN   = 4'd8;
  localparam logic [3:0] PH_EXP     = 4'd9;
  localparam logic [3:0] PH_SSTR    = 4'd10;
  localparam logic [3:0] PH_DSTR    = 4'd11;
  localparam logic [3:0] PH_COMMENT = 4'd12;

  // result kinds
  localparam logic [2:0] K_TEXT  = 3'd0;
  localparam logic [2:0] K_PUNCT = 3'd1;
  localparam logic [2:0] K_OPT   = 3'd2;
  localparam logic [2:0] K_ID    = 3'd3;
  localparam logic [2:0] K_PATH  = 3'd4;
  localparam logic [2:0] K_NUM   = 3'd5;
  localparam logic [2:0] K_STR   = 3'd6;
  localparam logic [2:0] K_END   = 3'd7;

  typedef struct packed {
    logic [3:0] phase;
    logic       text_nonempty;
  } lex_ctrl_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  ch;
    logic [15:0] line;
    logic [15:0] column;
  } result_t;

endpackage

// ===== rtl/core/clt_channels.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the tokenizer input and result items.
// Depends on nothing.
interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_input;

  modport source (output valid, data_byte, byte_valid, end_of_input, input ready);
  modport sink   (input valid, data_byte, byte_valid, end_of_input, output ready);
endinterface

interface clt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  char_out;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic        run_last;

  modport source (output valid, event_kind, char_out, start_line, start_column, run_last,
                  input ready);
  modport sink   (input valid, event_kind, char_out, start_line, start_column, run_last,
                  output ready);
endinterface

// ===== rtl/core/command_line_tokenizer_core.sv =====
`timescale 1ns / 1ps
// An accepted item is held in the input register; its results go to the result register.
// Throughput: one item per cycle while each item yields at most one result and out_chan is ready;
// an item with k results holds the result register until its last is taken, one result per
// cycle on out_chan while ready. Items that yield no result skip the result register.
// Reset (rst, synchronous): both stages empty, text phase, line 1, column 0.
module command_line_tokenizer_core #(
  parameter int POSITION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  clt_in_if.sink           in_chan,
  clt_out_if.source        out_chan
);
  import clt_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_ZERO = '0;
  localparam logic [POSITION_BITS-1:0] POS_ONE  = POSITION_BITS'(1);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_bv;
  logic       s1_eoi;

  // lexer state
  lex_ctrl_t                ctrl;
  logic [POSITION_BITS-1:0] line_count, column_count, token_line, token_column;

  lex_ctrl_t                ctrl_next;
  logic [POSITION_BITS-1:0] line_count_next, column_count_next;
  logic [POSITION_BITS-1:0] token_line_next, token_column_next;
  result_t [MAX_RESULTS-1:0] lex_results;
  logic [COUNT_W-1:0]        lex_count;

  // result register
  logic                      s2_valid;
  result_t [MAX_RESULTS-1:0] s2_results;
  logic [COUNT_W-1:0]        s2_count;
  logic [INDEX_W-1:0]        s2_idx;

  logic s2_last, s2_free, s1_go, s1_ends;

  clt_lexer #(.POSITION_BITS(POSITION_BITS)) u_lexer (
    .ctrl              (ctrl),
    .line_count        (line_count),
    .column_count      (column_count),
    .token_line        (token_line),
    .token_column      (token_column),
    .data_byte         (s1_byte),
    .byte_valid        (s1_bv),
    .end_of_input      (s1_eoi),
    .ctrl_next         (ctrl_next),
    .line_count_next   (line_count_next),
    .column_count_next (column_count_next),
    .token_line_next   (token_line_next),
    .token_column_next (token_column_next),
    .results           (lex_results),
    .result_count      (lex_count)
  );

  assign s2_last = (s2_idx == INDEX_W'(s2_count - 3'd1));
  assign s2_free = !s2_valid || (out_chan.ready && s2_last);
  // an item without results never waits for the result register
  assign s1_go   = s1_valid && ((lex_count == '0) || s2_free);
  assign s1_ends = s1_eoi || (s1_bv && s1_byte == 8'h00);

  assign in_chan.ready = !s1_valid || s1_go;

  assign out_chan.valid        = s2_valid;
  assign out_chan.event_kind   = s2_results[s2_idx].kind;
  assign out_chan.char_out     = s2_results[s2_idx].ch;
  assign out_chan.start_line   = s2_results[s2_idx].line;
  assign out_chan.start_column = s2_results[s2_idx].column;
  assign out_chan.run_last     = s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte <= in_chan.data_byte;
      s1_bv   <= in_chan.byte_valid;
      s1_eoi  <= in_chan.end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.phase         <= PH_TEXT;
      ctrl.text_nonempty <= 1'b0;
      line_count         <= POS_ONE;
      column_count       <= POS_ZERO;
      token_line         <= POS_ZERO;
      token_column       <= POS_ZERO;
    end else if (s1_go) begin
      ctrl         <= ctrl_next;
      line_count   <= line_count_next;
      column_count <= column_count_next;
      token_line   <= token_line_next;
      token_column <= token_column_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_idx   <= '0;
      s2_count <= '0;
    end else if (s1_go && lex_count != '0) begin
      s2_valid <= 1'b1;
      s2_idx   <= '0;
      s2_count <= lex_count;
    end else if (out_chan.valid && out_chan.ready) begin
      if (s2_last) begin
        s2_valid <= 1'b0;
      end else begin
        s2_idx <= s2_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && lex_count != '0) begin
      s2_results <= lex_results;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_count != '0) && (s2_count <= COUNT_W'(MAX_RESULTS)))
    else $error("result register holds an impossible count");

  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !out_chan.ready |=> $stable(s2_idx) && s2_valid)
    else $error("result index moved while output stalled");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_ends |=> ctrl.phase == PH_TEXT && !ctrl.text_nonempty &&
                         line_count == POS_ONE && column_count == POS_ZERO)
    else $error("lexer state not restored after end item");
`endif

endmodule

// ===== rtl/core/clt_lexer.sv =====
`timescale 1ns / 1ps
// Combinational step of the tokenizer: classifies one byte against the
// current phase and position and produces up to four result items. Uses clt_pkg.
module clt_lexer #(
  parameter int POSITION_BITS = 16
) (
  input  clt_pkg::lex_ctrl_t                          ctrl,
  input  logic [POSITION_BITS-1:0]                    line_count,
  input  logic [POSITION_BITS-1:0]                    column_count,
  input  logic [POSITION_BITS-1:0]                    token_line,
  input  logic [POSITION_BITS-1:0]                    token_column,
  input  logic [7:0]                                  data_byte,
  input  logic                                        byte_valid,
  input  logic                                        end_of_input,
  output clt_pkg::lex_ctrl_t                          ctrl_next,
  output logic [POSITION_BITS-1:0]                    line_count_next,
  output logic [POSITION_BITS-1:0]                    column_count_next,
  output logic [POSITION_BITS-1:0]                    token_line_next,
  output logic [POSITION_BITS-1:0]                    token_column_next,
  output clt_pkg::result_t [clt_pkg::MAX_RESULTS-1:0] results,
  output logic [clt_pkg::COUNT_W-1:0]                 result_count
);
  import clt_pkg::*;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EU    = 8'h45;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_E     = 8'h65;

  localparam logic [POSITION_BITS-1:0] POS_ZERO = '0;
  localparam logic [POSITION_BITS-1:0] POS_ONE  = POSITION_BITS'(1);

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || c == CH_UNDER;
  endfunction

  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
    return (&v) ? v : v + POS_ONE;
  endfunction

  function automatic result_t mk(input logic [2:0] kind, input logic [7:0] c,
                                 input logic [POSITION_BITS-1:0] l,
                                 input logic [POSITION_BITS-1:0] col_v);
    result_t r;
    r.kind   = kind;
    r.ch     = c;
    r.line   = 16'(l);
    r.column = 16'(col_v);
    return r;
  endfunction

  logic [3:0]               ph;
  logic                     tn;
  logic [POSITION_BITS-1:0] ln, col, tl, tc;
  logic [COUNT_W-1:0]       n;
  logic                     relex, is_char, ends, fopen;
  logic [2:0]               fk;
  logic [7:0]               c;
  result_t [MAX_RESULTS-1:0] res_v;

  always_comb begin
    ph    = ctrl.phase;
    tn    = ctrl.text_nonempty;
    ln    = line_count;
    col   = column_count;
    tl    = token_line;
    tc    = token_column;
    n     = '0;
    relex = 1'b0;
    fopen = 1'b0;
    fk    = K_END;
    res_v = '0;
    c       = data_byte;
    is_char = byte_valid && (c != 8'h00);
    ends    = end_of_input || (byte_valid && c == 8'h00);

    if (is_char) begin
      if (c == CH_NL) begin
        ln  = sat_inc(ln);
        col = POS_ONE;
      end else begin
        col = sat_inc(col);
      end

      unique case (ph) inside
        PH_TEXT: relex = 1'b1;
        PH_DASH: begin
          if (is_letter(c)) begin
            res_v[n[INDEX_W-1:0]] = mk(K_TEXT, c, tl, tc);
            n = n + 3'd1;
            res_v[n[INDEX_W-1:0]] = mk(K_OPT, 8'h00, tl, tc);
            n  = n + 3'd1;
            tn = 1'b0;
            ph = PH_TEXT;
          end else if (c == CH_DASH) begin
            ph = PH_OPT;
            tn = 1'b0;
          end else begin
            // lone dash: emit it as punctuation at its own position
            res_v[n[INDEX_W-1:0]] = mk(K_PUNCT, CH_DASH, tl, tc);
            n     = n + 3'd1;
            ph    = PH_TEXT;
            relex = 1'b1;
          end
        end
        PH_OPT: begin
          if ((!tn && is_letter(c)) || (tn && is_word(c))) begin
            res_v[n[INDEX_W-1:0]] = mk(K_TEXT, c, tl, tc);
            n  = n + 3'd1;
            tn = 1'b1;
          end else begin
            fopen = 1'b1;
            fk    = K_OPT;
          end
        end
        PH_ID: begin
          if (is_word(c) || c == CH_COLON || c == CH_SLASH || c == CH_DOT) begin
            res_v[n[INDEX_W-1:0]] = mk(K_TEXT, c, tl, tc);
            n  = n + 3'd1;
            tn = 1'b1;
            if (!is_word(c)) ph = PH_PATH;
          end else begin
            fopen = 1'b1;
            fk    = K_ID;
          end
        end
        PH_PATH: begin
          if (is_space(c)) begin
            res_v[n[INDEX_W-1:0]] = mk(K_PATH, 8'h00, tl, tc);
            n  = n + 3'd1;
            tn = 1'b0;
            ph = PH_TEXT;
          end else begin
            res_v[n[INDEX_W-1:0]] = mk(K_TEXT, c, tl, tc);
            n  = n + 3'd1;
            tn = 1'b1;
          end
        end
        PH_NUM: begin
          if (is_digit(c) || c == CH_DOT) begin
            res_v[n[INDEX_W-1:0]] = mk(K_TEXT, c, tl, tc);
            n  = n + 3'd1;
            tn = 1'b1;
            if (c == CH_DOT) ph = PH_FRAC;
          end else begin
            fopen = 1'b1;
            fk    = K_NUM;
          end
        end
        PH_FRAC: begin
          if (is_digit(c) || c == CH_E || c == CH_EU) begin
            res_v[n[INDEX_W-1:0]] = mk(K_TEXT, c, tl, tc);
            n  = n + 3'd1;
            tn = 1'b1;
            if (!is_digit(c)) ph = PH_EMARK;
          end else begin
            fopen = 1'b1;
            fk    = K_NUM;
          end
        end
        PH_EMARK: begin
          if (c == CH_DASH || c == CH_PLUS || is_digit(c)) begin
            res_v[n[INDEX_W-1:0]] = mk(K_TEXT, c, tl, tc);
            n  = n + 3'd1;
            tn = 1'b1;
            ph = is_digit(c) ? PH_EXP : PH_ESIGN;
          end else begin
            fopen = 1'b1;
            fk    = K_NUM;
          end
        end
        PH_ESIGN, PH_EXP: begin
          if (is_digit(c)) begin
            res_v[n[INDEX_W-1:0]] = mk(K_TEXT, c, tl, tc);
            n  = n + 3'd1;
            tn = 1'b1;
            ph = PH_EXP;
          end else begin
            fopen = 1'b1;
            fk    = K_NUM;
          end
        end
        PH_SSTR, PH_DSTR: begin
          if ((ph == PH_SSTR && c == CH_SQ) || (ph == PH_DSTR && c == CH_DQ)) begin
            res_v[n[INDEX_W-1:0]] = mk(K_STR, 8'h00, tl, tc);
            n  = n + 3'd1;
            tn = 1'b0;
            ph = PH_TEXT;
          end else begin
            res_v[n[INDEX_W-1:0]] = mk(K_TEXT, c, tl, tc);
            n  = n + 3'd1;
            tn = 1'b1;
          end
        end
        PH_COMMENT: begin
          if (c == CH_NL) ph = PH_TEXT;
        end
        default: begin
          ph    = PH_TEXT;
          relex = 1'b1;
        end
      endcase

      // token ended by this byte: close it, then lex the byte again
      if (fopen) begin
        res_v[n[INDEX_W-1:0]] = mk(fk, 8'h00, tl, tc);
        n     = n + 3'd1;
        tn    = 1'b0;
        ph    = PH_TEXT;
        relex = 1'b1;
      end

      if (relex) begin
        if (c == CH_DASH || c == CH_DQ || c == CH_SQ || is_digit(c) || is_letter(c)) begin
          tl = ln;
          tc = col;
          tn = 1'b0;
        end
        if (c == CH_DASH) begin
          ph = PH_DASH;
        end else if (c == CH_DQ) begin
          ph = PH_DSTR;
        end else if (c == CH_SQ) begin
          ph = PH_SSTR;
        end else if (c == CH_HASH) begin
          ph = PH_COMMENT;
        end else if (is_digit(c) || is_letter(c)) begin
          ph = is_digit(c) ? PH_NUM : PH_ID;
          res_v[n[INDEX_W-1:0]] = mk(K_TEXT, c, tl, tc);
          n  = n + 3'd1;
          tn = 1'b1;
        end else if (!is_space(c)) begin
          res_v[n[INDEX_W-1:0]] = mk(K_PUNCT, c, ln, col);
          n = n + 3'd1;
        end
      end
    end

    if (ends) begin
      fopen = 1'b0;
      fk    = K_END;
      unique case (ph) inside
        PH_DASH: begin
          res_v[n[INDEX_W-1:0]] = mk(K_PUNCT, CH_DASH, tl, tc);
          n = n + 3'd1;
        end
        PH_PATH: begin
          fopen = 1'b1;
          fk    = K_PATH;
        end
        PH_OPT: begin
          fopen = tn;
          fk    = K_OPT;
        end
        PH_ID: begin
          fopen = tn;
          fk    = K_ID;
        end
        PH_NUM, PH_FRAC, PH_EMARK, PH_ESIGN, PH_EXP: begin
          fopen = tn;
          fk    = K_NUM;
        end
        PH_SSTR, PH_DSTR: begin
          fopen = tn;
          fk    = K_STR;
        end
        default: fopen = 1'b0;
      endcase
      if (fopen) begin
        res_v[n[INDEX_W-1:0]] = mk(fk, 8'h00, tl, tc);
        n = n + 3'd1;
      end
      col = sat_inc(col);
      res_v[n[INDEX_W-1:0]] = mk(K_END, 8'h00, ln, col);
      n = n + 3'd1;
      // back to the reset state for the next stream
      ph  = PH_TEXT;
      tn  = 1'b0;
      ln  = POS_ONE;
      col = POS_ZERO;
      tl  = POS_ZERO;
      tc  = POS_ZERO;
    end

    ctrl_next.phase         = ph;
    ctrl_next.text_nonempty = tn;
    line_count_next         = ln;
    column_count_next       = col;
    token_line_next         = tl;
    token_column_next       = tc;
    results                 = res_v;
    result_count            = n;
  end

endmodule

// ===== dv/command_line_tokenizer_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for command_line_tokenizer_core: random and directed byte streams
// with a class-based token predictor. Depends on clt_pkg, clt_channels and the core RTL.
module command_line_tokenizer_core_tb;
  import clt_pkg::*;

  localparam int POS_BITS       = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_ITEMS    = 16;

  typedef struct packed {
    result_t res;
    logic    last;
  } token_event_t;

  typedef struct {
    logic [7:0] data;
    logic       bv;
    logic       fin;
  } char_item_t;

  class token_scoreboard;
    logic [3:0]          phase;
    bit                  nonempty;
    logic [POS_BITS-1:0] line_no;
    logic [POS_BITS-1:0] col_no;
    logic [POS_BITS-1:0] tok_line;
    logic [POS_BITS-1:0] tok_col;
    result_t             step_events[$];
    token_event_t        expected_events[$];
    int                  errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      phase    = PH_TEXT;
      nonempty = 1'b0;
      line_no  = 1;
      col_no   = 0;
      tok_line = 0;
      tok_col  = 0;
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    function logic [POS_BITS-1:0] bump(logic [POS_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function bit is_word(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function void emit(logic [2:0] kind, logic [7:0] ch, logic [POS_BITS-1:0] ln,
                       logic [POS_BITS-1:0] col);
      result_t r;
      if (step_events.size() >= MAX_RESULTS) return;
      r.kind   = kind;
      r.ch     = ch;
      r.line   = 16'(ln);
      r.column = 16'(col);
      step_events.push_back(r);
    endfunction

    function void put_text(logic [7:0] c);
      emit(K_TEXT, c, tok_line, tok_col);
      nonempty = 1'b1;
    endfunction

    function void open_token(logic [3:0] ph);
      tok_line = line_no;
      tok_col  = col_no;
      nonempty = 1'b0;
      phase    = ph;
    endfunction

    function void close_token(logic [2:0] kind);
      emit(kind, 8'h00, tok_line, tok_col);
      nonempty = 1'b0;
      phase    = PH_TEXT;
    endfunction

    function void lex_text(logic [7:0] c);
      if (c == "-") open_token(PH_DASH);
      else if (c == "\"") open_token(PH_DSTR);
      else if (c == "'") open_token(PH_SSTR);
      else if (c == "#") phase = PH_COMMENT;
      else if (is_digit(c)) begin
        open_token(PH_NUM);
        put_text(c);
      end else if (is_alpha(c)) begin
        open_token(PH_ID);
        put_text(c);
      end else if (!is_blank(c)) emit(K_PUNCT, c, line_no, col_no);
    endfunction

    // Returns 1 when the byte ends the open token and must be lexed again from text.
    function bit lex_open(logic [7:0] c);
      bit relex;
      relex = 1'b0;
      case (phase)
        PH_DASH: begin
          if (is_alpha(c)) begin
            put_text(c);
            close_token(K_OPT);
          end else if (c == "-") begin
            phase    = PH_OPT;
            nonempty = 1'b0;
          end else begin
            emit(K_PUNCT, "-", tok_line, tok_col);
            phase = PH_TEXT;
            relex = 1'b1;
          end
        end
        PH_OPT: begin
          if ((!nonempty && is_alpha(c)) || (nonempty && is_word(c))) put_text(c);
          else begin
            close_token(K_OPT);
            relex = 1'b1;
          end
        end
        PH_ID: begin
          if (is_word(c)) put_text(c);
          else if (c == ":" || c == "/" || c == ".") begin
            put_text(c);
            phase = PH_PATH;
          end else begin
            close_token(K_ID);
            relex = 1'b1;
          end
        end
        PH_PATH: begin
          if (is_blank(c)) close_token(K_PATH);
          else put_text(c);
        end
        PH_NUM: begin
          if (is_digit(c)) put_text(c);
          else if (c == ".") begin
            put_text(c);
            phase = PH_FRAC;
          end else begin
            close_token(K_NUM);
            relex = 1'b1;
          end
        end
        PH_FRAC: begin
          if (is_digit(c)) put_text(c);
          else if (c == "e" || c == "E") begin
            put_text(c);
            phase = PH_EMARK;
          end else begin
            close_token(K_NUM);
            relex = 1'b1;
          end
        end
        PH_EMARK: begin
          if (c == "-" || c == "+") begin
            put_text(c);
            phase = PH_ESIGN;
          end else if (is_digit(c)) begin
            put_text(c);
            phase = PH_EXP;
          end else begin
            close_token(K_NUM);
            relex = 1'b1;
          end
        end
        PH_ESIGN, PH_EXP: begin
          if (is_digit(c)) begin
            put_text(c);
            phase = PH_EXP;
          end else begin
            close_token(K_NUM);
            relex = 1'b1;
          end
        end
        PH_SSTR: begin
          if (c == "'") close_token(K_STR);
          else put_text(c);
        end
        PH_DSTR: begin
          if (c == "\"") close_token(K_STR);
          else put_text(c);
        end
        PH_COMMENT: begin
          if (c == "\n") phase = PH_TEXT;
        end
        default: begin
          phase = PH_TEXT;
          relex = 1'b1;
        end
      endcase
      return relex;
    endfunction

    function void note_byte_item(logic [7:0] c, logic bv, logic fin);
      bit           ends;
      token_event_t ev;
      ends = fin || (bv && c == 8'h00);
      step_events.delete();
      if (bv && c != 8'h00) begin
        if (c == "\n") begin
          line_no = bump(line_no);
          col_no  = 1;
        end else col_no = bump(col_no);
        if (phase == PH_TEXT) lex_text(c);
        else if (lex_open(c)) lex_text(c);
      end
      if (ends) begin
        // flush the open token; only tokens with text close, except a path or a held dash
        case (phase)
          PH_DASH: emit(K_PUNCT, "-", tok_line, tok_col);
          PH_PATH: close_token(K_PATH);
          PH_OPT:  if (nonempty) close_token(K_OPT);
          PH_ID:   if (nonempty) close_token(K_ID);
          PH_NUM, PH_FRAC, PH_EMARK, PH_ESIGN, PH_EXP: if (nonempty) close_token(K_NUM);
          PH_SSTR, PH_DSTR: if (nonempty) close_token(K_STR);
          default: ;
        endcase
        col_no = bump(col_no);
        emit(K_END, 8'h00, line_no, col_no);
        restart();
      end
      foreach (step_events[i]) begin
        ev.res  = step_events[i];
        ev.last = (i == step_events.size() - 1);
        expected_events.push_back(ev);
      end
    endfunction

    function void check_token_event(logic [2:0] kind, logic [7:0] ch, logic [15:0] ln,
                                    logic [15:0] col, logic last);
      token_event_t want;
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind=%0d char=%02h line=%0d col=%0d last=%0b",
                   kind, ch, ln, col, last);
        return;
      end
      want = expected_events.pop_front();
      if (want.res.kind !== kind || want.res.ch !== ch || want.res.line !== ln ||
          want.res.column !== col || want.last !== last) begin
        errors++;
        if (errors <= 10)
          $display({"result mismatch: expected kind=%0d char=%02h line=%0d col=%0d ",
                    "last=%0b, got kind=%0d char=%02h line=%0d col=%0d last=%0b"},
                   want.res.kind, want.res.ch, want.res.line, want.res.column, want.last,
                   kind, ch, ln, col, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  clt_in_if  in_chan ();
  clt_out_if out_chan ();

  command_line_tokenizer_core #(
    .POSITION_BITS(POS_BITS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  token_scoreboard sb = new();
  char_item_t      feed_q[$];
  int              send_idle_pct = 0;
  int              stall_pct = 0;
  bit              hold_req = 1'b0;
  int              quiet_cycles = 0;
  int              idle_tab[4] = '{0, 47, 0, 15};
  int              stall_tab[4] = '{0, 0, 47, 15};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_chan.valid && out_chan.ready)
        sb.check_token_event(out_chan.event_kind, out_chan.char_out, out_chan.start_line,
                             out_chan.start_column, out_chan.run_last);
      if (in_chan.valid && in_chan.ready)
        sb.note_byte_item(in_chan.data_byte, in_chan.byte_valid, in_chan.end_of_input);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic push_item(logic [7:0] data, logic bv, logic fin);
    char_item_t it;
    it.data = data;
    it.bv   = bv;
    it.fin  = fin;
    feed_q.push_back(it);
  endtask

  task automatic push_string(string s);
    foreach (s[i]) push_item(s[i], 1'b1, 1'b0);
  endtask

  function automatic logic [7:0] rand_alpha();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'h41 + 8'(r) : 8'h61 + 8'(r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_word();
    int r;
    r = $urandom_range(0, 62);
    if (r < 52) return rand_alpha();
    if (r < 62) return rand_digit();
    return "_";
  endfunction

  function automatic logic [7:0] rand_blank();
    string s;
    s = " \t\n\r\v\f  ";
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_punct();
    string s;
    s = "!$%&()*+,;<=>?@[]^`{|}~/:.";
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(128, 255));
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic push_digits(int lo, int hi);
    repeat ($urandom_range(lo, hi)) push_item(rand_digit(), 1'b1, 1'b0);
  endtask

  task automatic push_quoted(logic [7:0] quote, int max_len);
    logic [7:0] c;
    push_item(quote, 1'b1, 1'b0);
    repeat ($urandom_range(0, max_len)) begin
      c = 8'($urandom_range(1, 255));
      if (c == quote) c = "x";
      push_item(c, 1'b1, 1'b0);
    end
    push_item(quote, 1'b1, 1'b0);
  endtask

  task automatic add_random_token();
    case ($urandom_range(0, 15))
      0: begin
        push_item("-", 1'b1, 1'b0);
        push_item(rand_alpha(), 1'b1, 1'b0);
      end
      1: begin
        push_string("--");
        push_item(rand_alpha(), 1'b1, 1'b0);
        repeat ($urandom_range(0, 4)) push_item(rand_word(), 1'b1, 1'b0);
      end
      2: push_string("--");
      3: begin
        push_item(rand_alpha(), 1'b1, 1'b0);
        repeat ($urandom_range(0, 4)) push_item(rand_word(), 1'b1, 1'b0);
      end
      4: begin
        push_item(rand_alpha(), 1'b1, 1'b0);
        repeat ($urandom_range(0, 2)) push_item(rand_word(), 1'b1, 1'b0);
        case ($urandom_range(0, 2))
          0: push_item(":", 1'b1, 1'b0);
          1: push_item("/", 1'b1, 1'b0);
          default: push_item(".", 1'b1, 1'b0);
        endcase
        repeat ($urandom_range(0, 4)) push_item(8'($urandom_range(33, 126)), 1'b1, 1'b0);
      end
      5: push_digits(1, 5);
      6: begin
        push_digits(1, 3);
        push_item(".", 1'b1, 1'b0);
        push_digits(0, 3);
      end
      7: begin
        push_digits(1, 2);
        push_item(".", 1'b1, 1'b0);
        push_digits(0, 2);
        push_item($urandom_range(0, 1) ? "e" : "E", 1'b1, 1'b0);
        if ($urandom_range(0, 1)) push_item($urandom_range(0, 1) ? "-" : "+", 1'b1, 1'b0);
        push_digits(1, 3);
      end
      8: begin
        // exponent mark, maybe a sign, then no digit
        push_digits(1, 2);
        push_item(".", 1'b1, 1'b0);
        push_digits(0, 2);
        push_item("e", 1'b1, 1'b0);
        if ($urandom_range(0, 1)) push_item($urandom_range(0, 1) ? "-" : "+", 1'b1, 1'b0);
        push_item($urandom_range(0, 1) ? rand_alpha() : rand_punct(), 1'b1, 1'b0);
      end
      9:  push_quoted($urandom_range(0, 1) ? "'" : "\"", 5);
      10: push_quoted($urandom_range(0, 1) ? "'" : "\"", 0);
      11: begin
        push_item("#", 1'b1, 1'b0);
        repeat ($urandom_range(0, 4)) push_item(8'($urandom_range(32, 255)), 1'b1, 1'b0);
        push_item("\n", 1'b1, 1'b0);
      end
      12: push_item(rand_punct(), 1'b1, 1'b0);
      13: begin
        push_item("-", 1'b1, 1'b0);
        case ($urandom_range(0, 2))
          0: push_item(rand_digit(), 1'b1, 1'b0);
          1: push_item(rand_blank(), 1'b1, 1'b0);
          default: push_item(rand_punct(), 1'b1, 1'b0);
        endcase
      end
      14: push_item(rand_blank(), 1'b1, 1'b0);
      default: push_item(8'($urandom_range(1, 255)), 1'b1, 1'b0);
    endcase
  endtask

  task automatic add_random_stream();
    repeat ($urandom_range(1, 5)) begin
      add_random_token();
      if ($urandom_range(0, 11) == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if ($urandom_range(0, 3) != 0) push_item(rand_blank(), 1'b1, 1'b0);
    end
    case ($urandom_range(0, 3))
      0: push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      1: push_item(8'h00, 1'b1, 1'b0);
      2: push_item(8'h00, 1'b1, 1'b1);
      default: push_item(rand_alpha(), 1'b1, 1'b1);
    endcase
  endtask

  task automatic drive_feed();
    int idx;
    idx = 0;
    while (idx < feed_q.size()) begin
      @(negedge clk);
      if ($urandom_range(0, 99) < send_idle_pct) begin
        in_chan.valid <= 1'b0;
      end else begin
        in_chan.valid        <= 1'b1;
        in_chan.data_byte    <= feed_q[idx].data;
        in_chan.byte_valid   <= feed_q[idx].bv;
        in_chan.end_of_input <= feed_q[idx].fin;
        @(posedge clk);
        while (!in_chan.ready) @(posedge clk);
        idx++;
      end
    end
    @(negedge clk);
    in_chan.valid <= 1'b0;
    feed_q.delete();
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    in_chan.valid        = 1'b0;
    in_chan.data_byte    = 8'h00;
    in_chan.byte_valid   = 1'b0;
    in_chan.end_of_input = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: options, lone dash, path, bad exponent, empty string, comment,
    // zero byte end, top byte, bare item, held dashes at end
    push_string("-a --b_1 -5");
    push_item(8'h00, 1'b1, 1'b0);
    push_string("x:y 1.eq ''");
    push_item(8'hFF, 1'b1, 1'b1);
    push_item(8'h00, 1'b0, 1'b0);
    push_string("#\n--");
    push_item(8'h00, 1'b0, 1'b1);
    push_string("-");
    push_item(8'hFF, 1'b0, 1'b1);
    drive_feed();
    wait_drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_tab[p];
      stall_pct     = stall_tab[p];
      while (feed_q.size() < PHASE_ITEMS) add_random_stream();
      // let the block back up against a stopped receiver
      if (p == 0) hold_req = 1'b1;
      drive_feed();
      wait_drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
